// ----- sv/sta_pkg.sv -----
// Shared constants and types for the triple-angle sine block.
// No dependencies; imported by every module of the block.
package sta_pkg;

  localparam int MAX_REDUCTIONS  = 16;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int WORK_FRAC       = 30;
  localparam int THR_BITS        = 16;

  // Working magnitude width, rounded up to whole base-4 digits.
  localparam int XW_RAW = 32 + WORK_FRAC - ANGLE_FRAC_BITS;
  localparam int XW     = ((XW_RAW + 1) / 2) * 2;
  localparam int NDIG   = XW / 2;

  // Link between neighboring cells: one base-4 digit per cycle.
  typedef struct packed {
    logic       vld;
    logic       first;
    logic [1:0] dig;
    logic [1:0] tdig;
  } sta_link_t;

endpackage

// ----- sv/sta_div3_cell.sv -----
// One cell of the reduction chain: digit-serial divide by three and compare.
// Depends on sta_pkg.
module sta_div3_cell
  import sta_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  sta_link_t       link_in,
  output sta_link_t       link_out,
  output logic [XW-1:0]   quot,
  output logic            ge
);

  logic [1:0] rem;
  logic       gt;
  logic       lt;
  logic [1:0] rem_eff;
  logic       gt_eff;
  logic       lt_eff;
  logic [3:0] v;
  logic [1:0] qd;
  logic [1:0] rem_next;

  // Long division by three, most significant digit first.
  always_comb begin
    rem_eff = link_in.first ? 2'd0 : rem;
    gt_eff  = link_in.first ? 1'b0 : gt;
    lt_eff  = link_in.first ? 1'b0 : lt;
    v = {rem_eff, link_in.dig};
    if (v >= 4'd9) begin
      qd = 2'd3;
      rem_next = 2'(v - 4'd9);
    end else if (v >= 4'd6) begin
      qd = 2'd2;
      rem_next = 2'(v - 4'd6);
    end else if (v >= 4'd3) begin
      qd = 2'd1;
      rem_next = 2'(v - 4'd3);
    end else begin
      qd = 2'd0;
      rem_next = v[1:0];
    end
  end

  // The input value is at or above the threshold unless it compared lower.
  assign ge = !lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.vld <= 1'b0;
    end else begin
      link_out.vld <= link_in.vld;
    end
    link_out.first <= link_in.first;
    link_out.dig   <= qd;
    link_out.tdig  <= link_in.tdig;
    if (link_in.vld) begin
      rem  <= rem_next;
      quot <= {quot[XW-3:0], qd};
      gt   <= gt_eff | (!lt_eff && (link_in.dig > link_in.tdig));
      lt   <= lt_eff | (!gt_eff && (link_in.dig < link_in.tdig));
    end
  end

endmodule

// ----- sv/sine_triple_angle_reduction_top.sv -----
// Top level of the triple-angle sine block; instantiates the cell chain.
// Depends on sta_pkg and sta_div3_cell.
//
// The magnitude streams through a row of divide-by-three cells two bits per
// cycle, so the chain length and the word width set the length of the stream
// phase; one shared multiplier then works each triple-angle step in the states
// SQ and CUBE. One word is worked on at a time; a new angle is taken while the
// previous sine still waits in the output register.
module sine_triple_angle_reduction_top
  import sta_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] sine,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  localparam int SLEN = NDIG + MAX_REDUCTIONS;
  localparam int CW   = $clog2(SLEN + 1);
  localparam int KW   = $clog2(MAX_REDUCTIONS + 1);
  localparam logic signed [31:0] ONE = 32'sd1 <<< WORK_FRAC;

  typedef enum logic [2:0] {IDLE, STREAM, PICK, SQ, CUBE, FINISH} state_t;

  state_t             state;
  logic [15:0]        thr;
  logic               neg;
  logic [XW-1:0]      x_hold;
  logic [XW-1:0]      xs;
  logic [XW-1:0]      ts;
  logic [CW-1:0]      cnt;
  logic [KW-1:0]      steps;
  logic signed [31:0] s;
  logic [30:0]        sq;

  sta_link_t          links [0:MAX_REDUCTIONS];
  logic [XW-1:0]      quots [0:MAX_REDUCTIONS-1];
  logic [XW-1:0]      qv    [0:MAX_REDUCTIONS];
  logic [MAX_REDUCTIONS-1:0] ge;

  logic [31:0]        mag;
  logic [KW-1:0]      k_sel;
  logic [XW-1:0]      sel;
  logic [30:0]        m;
  logic [30:0]        mul_a;
  logic [61:0]        prod;
  logic signed [33:0] cube;
  logic signed [33:0] tnew;
  logic signed [31:0] s_step;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == IDLE);
  assign mag       = angle[31] ? (32'd0 - angle) : angle;

  // Feed the first cell with the magnitude and threshold digits.
  assign links[0].vld   = (state == STREAM) && (cnt < CW'(NDIG));
  assign links[0].first = (state == STREAM) && (cnt == '0);
  assign links[0].dig   = xs[XW-1:XW-2];
  assign links[0].tdig  = ts[XW-1:XW-2];

  for (genvar k = 0; k < MAX_REDUCTIONS; k++) begin : g_cell
    sta_div3_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .link_in  (links[k]),
      .link_out (links[k+1]),
      .quot     (quots[k]),
      .ge       (ge[k])
    );
  end

  // Reduction count is the first cell whose input fell below the threshold.
  always_comb begin
    k_sel = KW'(MAX_REDUCTIONS);
    for (int k = MAX_REDUCTIONS - 1; k >= 0; k--) begin
      if (!ge[k]) k_sel = KW'(k);
    end
    qv[0] = x_hold;
    for (int k = 1; k <= MAX_REDUCTIONS; k++) begin
      qv[k] = quots[k-1];
    end
    sel = qv[k_sel];
  end

  // Shared multiplier datapath for s = 3s - 4s^3: the square in SQ, the
  // cube in CUBE.
  always_comb begin
    m       = s[31] ? 31'(-s) : s[30:0];
    mul_a   = (state == CUBE) ? sq : m;
    prod    = 62'(mul_a) * 62'(m);
    cube    = s[31] ? -34'(signed'({1'b0, prod[60:30]}))
                    : 34'(signed'({1'b0, prod[60:30]}));
    tnew    = 34'(s) * 34'sd3 - (cube <<< 2);
    if (tnew > 34'(ONE)) s_step = ONE;
    else if (tnew < -34'(ONE)) s_step = -ONE;
    else s_step = tnew[31:0];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 16'd655;
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  // Sequencer and output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      steps     <= '0;
    end else begin
      if ((state == FINISH) && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            neg    <= angle[31];
            x_hold <= XW'(mag) << (WORK_FRAC - ANGLE_FRAC_BITS);
            xs     <= XW'(mag) << (WORK_FRAC - ANGLE_FRAC_BITS);
            ts     <= XW'(thr) << (WORK_FRAC - THR_BITS);
            cnt    <= '0;
            state  <= STREAM;
          end
        end
        STREAM: begin
          xs <= xs << 2;
          ts <= ts << 2;
          if (cnt == CW'(SLEN - 1)) state <= PICK;
          else cnt <= cnt + 1'b1;
        end
        PICK: begin
          steps <= k_sel;
          s     <= (sel > XW'(ONE)) ? ONE : sel[31:0];
          state <= (k_sel == '0) ? FINISH : SQ;
        end
        SQ: begin
          sq    <= prod[60:30];
          state <= CUBE;
        end
        CUBE: begin
          s     <= s_step;
          steps <= steps - 1'b1;
          state <= (steps == KW'(1)) ? FINISH : SQ;
        end
        FINISH: begin
          if (!out_valid || out_ready) begin
            sine  <= neg ? -s : s;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- sim/sine_triple_angle_reduction_checker.sv -----
// Checker for the triple-angle sine block: watches the angle, sine and
// threshold channels, predicts each sine word and compares. Uses sta_pkg.
`timescale 1ns / 100ps

module sine_triple_angle_reduction_checker
  import sta_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] angle,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] sine,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_sines
);

  localparam longint ONE_Q30 = longint'(1) << WORK_FRAC;

  logic [15:0] threshold;
  logic signed [31:0] sine_queue[$];

  // Saturated triple-angle step with the cube truncated toward zero.
  function automatic longint triple_angle(input longint s);
    longint mag;
    longint sq;
    longint cube;
    longint r;
    begin
      mag  = (s < 0) ? -s : s;
      sq   = (mag * mag) >>> WORK_FRAC;
      cube = (sq * mag) >>> WORK_FRAC;
      if (s < 0) begin
        cube = -cube;
      end
      r = 3 * s - 4 * cube;
      if (r > ONE_Q30) begin
        r = ONE_Q30;
      end else if (r < -ONE_Q30) begin
        r = -ONE_Q30;
      end
      return r;
    end
  endfunction

  // Full sine prediction for one angle word.
  function automatic logic signed [31:0] predict_sine(input logic [31:0] raw,
                                                     input logic [15:0] thr_q16);
    logic        neg;
    logic [31:0] mag;
    longint      x;
    longint      thr;
    longint      s;
    int          count;
    begin
      neg   = raw[31];
      mag   = neg ? (32'd0 - raw) : raw;
      x     = longint'({32'd0, mag}) << (WORK_FRAC - ANGLE_FRAC_BITS);
      thr   = longint'(thr_q16) << (WORK_FRAC - 16);
      count = 0;
      while (x >= thr && count < MAX_REDUCTIONS) begin
        x = x / 3;
        count++;
      end
      s = (x > ONE_Q30) ? ONE_Q30 : x;
      for (int i = 0; i < count; i++) begin
        s = triple_angle(s);
      end
      if (neg) begin
        s = -s;
      end
      return s[31:0];
    end
  endfunction

  task automatic report_mismatch(input string msg);
    begin
      $display("[%0t] ERROR: %s", $realtime, msg);
      fail_count++;
    end
  endtask

  assign pending_sines = sine_queue.size();

  // Track configuration, queue predictions and check each sine word.
  always @(posedge clk) begin
    if (rst) begin
      threshold  <= 16'd655;
      sine_queue.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        threshold <= cfg_data;
      end
      if (in_valid && in_ready) begin
        sine_queue.push_back(predict_sine(angle, threshold));
      end
      if (out_valid && out_ready) begin
        if (sine_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected sine word %h", sine));
        end else if (sine !== sine_queue[0]) begin
          report_mismatch($sformatf("sine %h, predicted %h", sine, sine_queue[0]));
          void'(sine_queue.pop_front());
        end else begin
          void'(sine_queue.pop_front());
        end
      end
    end
  end

endmodule

// ----- sim/sine_triple_angle_reduction_top_tb.sv -----
// Testbench top for the triple-angle sine block: clock, reset, stimulus
// and verdict. Depends on sta_pkg, the block and the checker module.
`timescale 1ns / 100ps

module sine_triple_angle_reduction_top_tb;
  import sta_pkg::*;

  localparam int DRAIN_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 1000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] angle = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] sine;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_data = '0;
  int                 fail_count;
  int                 pending_sines;
  longint             cycle_count = 0;
  int                 burst_left = 0;

  always #4 clk = ~clk;

  sine_triple_angle_reduction_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .angle(angle),
    .out_valid(out_valid), .out_ready(out_ready), .sine(sine),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  sine_triple_angle_reduction_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .angle(angle),
    .out_valid(out_valid), .out_ready(out_ready), .sine(sine),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_sines(pending_sines)
  );

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver stalls: long open stretches, then phases of random stalls.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (cycle_count[11:9] == 3'd2) begin
      out_ready <= 1'b1;
    end else if (cycle_count[8]) begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ready <= ($urandom_range(0, 3) == 0);
    end
  end

  // Send one angle word, with bursts and random gaps. Valid stays high
  // within a burst; this task drops it only for a gap.
  task automatic send_angle(input logic [31:0] value);
    int gap;
    begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 60);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      in_valid <= 1'b1;
      angle    <= value;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
    end
  endtask

  // Wait for every predicted sine, then let the block settle.
  task automatic drain_sines;
    begin
      in_valid <= 1'b0;
      while (pending_sines != 0) @(negedge clk);
      repeat (DRAIN_CYCLES) @(negedge clk);
    end
  endtask

  // Write the threshold while the block is idle.
  task automatic write_threshold(input logic [15:0] value);
    begin
      drain_sines();
      cfg_valid <= 1'b1;
      cfg_data  <= value;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
      cfg_valid <= 1'b0;
    end
  endtask

  // Random angle: mostly moderate magnitudes, some full-range words.
  function automatic logic [31:0] random_angle();
    logic [31:0] v;
    begin
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = $urandom_range(0, 32'h0006_4800);
        2: v = 32'd0 - $urandom_range(0, 32'h0006_4800);
        default: v = $urandom >> $urandom_range(0, 31);
      endcase
      return v;
    end
  endfunction

  initial begin
    logic [31:0] directed[$];
    logic [15:0] thresholds[6];

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words at the reset threshold: extremes and small angles.
    directed = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0001, 32'h0001_0000, 32'hFFFF_0000,
                 32'h0003_243F, 32'hFFFC_DBC1, 32'h0001_921F, 32'h0000_028E,
                 32'h0000_028F, 32'h5555_5555, 32'hAAAA_AAAA};
    foreach (directed[i]) send_angle(directed[i]);

    // Threshold sweep with its extremes, including zero, which forces every reduction.
    thresholds = '{16'd1, 16'hFFFF, 16'd0, 16'd655, 16'h8000, 16'd7};
    foreach (thresholds[t]) begin
      write_threshold(thresholds[t]);
      send_angle(32'h8000_0000);
      send_angle(32'h7FFF_FFFF);
      send_angle(32'h0000_FFFF);
      for (int n = 0; n < 160; n++) begin
        send_angle(random_angle());
      end
    end

    drain_sines();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/sta_pkg.sv
sv/sta_div3_cell.sv
sv/sine_triple_angle_reduction_top.sv
sim/sine_triple_angle_reduction_checker.sv
sim/sine_triple_angle_reduction_top_tb.sv
